### rtl/otv_pkg.sv
package otv_pkg;

  localparam int WINDOW_SAMPLES_DEF = 8;
  localparam int QUEUE_DEPTH        = 2;
  localparam int WARMUP_SKIP        = 2;

  localparam int TICK_W   = 24;
  localparam int MARGIN_W = 4;
  localparam int TUNE_W   = 6;
  localparam int DATA_W   = 32;
  localparam int ADDR_W   = 3;

  localparam logic [TICK_W-1:0]          TARGET_RESET = 24'd1000000;
  localparam logic [MARGIN_W-1:0]        MARGIN_RESET = 4'd1;
  localparam logic signed [TUNE_W-1:0]   TUNE_MIN     = 6'sb100000;
  localparam logic signed [TUNE_W-1:0]   TUNE_MAX     = 6'sb011111;
  localparam logic signed [TUNE_W-1:0]   TUNE_STEP    = 6'sd1;

  localparam logic CMD_RECORD = 1'b0;
  localparam logic CMD_EVAL   = 1'b1;

  localparam logic REG_TARGET = 1'b0;
  localparam logic REG_MARGIN = 1'b1;

  typedef enum logic [1:0] {
    KIND_SKIP  = 2'd0,
    KIND_STORE = 2'd1,
    KIND_VOTE  = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ACT_NONE = 2'd0,
    ACT_DOWN = 2'd1,
    ACT_UP   = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    BK_IDLE   = 2'd0,
    BK_WALK   = 2'd1,
    BK_DRAIN  = 2'd2,
    BK_DECIDE = 2'd3
  } back_state_t;

  typedef struct packed {
    kind_t             kind;
    logic [TICK_W-1:0] ticks;
    logic              full;
  } desc_t;

  typedef struct packed {
    logic signed [TUNE_W-1:0] tune;
    action_t                  action;
    logic                     full;
  } res_t;

endpackage

### rtl/otv_fifo.sv
module otv_fifo
  import otv_pkg::*;
#(
  parameter int WIDTH = 8,
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_i,
  input  logic [WIDTH-1:0] din_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] dout_o,
  output logic             empty_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full_o  = (cnt_r == FULL_CNT);
  assign empty_o = (cnt_r == '0);
  assign dout_o  = slot_r[rd_ptr_r];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= din_i;
    end
  end

endmodule

### rtl/otv_front.sv
module otv_front
  import otv_pkg::*;
#(
  parameter int WINDOW_SAMPLES = WINDOW_SAMPLES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push_i,
  input  logic              cmd_i,
  input  logic [TICK_W-1:0] ticks_i,
  input  logic              q_full_i,
  output logic              q_push_o,
  output desc_t             q_desc_o
);

  localparam int FILL_W = $clog2(WINDOW_SAMPLES + WARMUP_SKIP + 1);
  localparam logic [FILL_W-1:0] FULL_LEVEL = FILL_W'(WINDOW_SAMPLES + WARMUP_SKIP);
  localparam logic [FILL_W-1:0] SKIP_LEVEL = FILL_W'(WARMUP_SKIP);

  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic              accept;

  assign accept   = push_i && !q_full_i;
  assign q_push_o = accept;

  always_comb begin
    fill_nxt       = fill_r;
    q_desc_o.ticks = ticks_i;
    q_desc_o.kind  = KIND_SKIP;
    q_desc_o.full  = (fill_r == FULL_LEVEL);
    if (cmd_i == CMD_RECORD) begin
      // warm-up records only advance the fill level
      q_desc_o.kind = (fill_r < SKIP_LEVEL) ? KIND_SKIP : KIND_STORE;
      if (fill_r != FULL_LEVEL) begin
        fill_nxt = fill_r + 1'b1;
      end
      q_desc_o.full = (fill_nxt == FULL_LEVEL);
    end else begin
      q_desc_o.kind = (fill_r == FULL_LEVEL) ? KIND_VOTE : KIND_SKIP;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else if (accept) begin
      fill_r <= fill_nxt;
    end
  end

endmodule

### rtl/otv_back.sv
module otv_back
  import otv_pkg::*;
#(
  parameter int WINDOW_SAMPLES = WINDOW_SAMPLES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_empty_i,
  input  desc_t               q_desc_i,
  output logic                q_pop_o,
  input  logic [TICK_W-1:0]   target_i,
  input  logic [MARGIN_W-1:0] margin_i,
  input  logic                r_full_i,
  output logic                r_push_o,
  output res_t                r_res_o
);

  localparam int PTR_W  = (WINDOW_SAMPLES > 1) ? $clog2(WINDOW_SAMPLES) : 1;
  localparam int CNT_W  = $clog2(WINDOW_SAMPLES + 1);
  localparam int VOTE_W = CNT_W + MARGIN_W + 1;
  localparam logic [PTR_W-1:0] LAST_IDX = PTR_W'(WINDOW_SAMPLES - 1);

  logic [TICK_W-1:0]        win_mem [WINDOW_SAMPLES];
  back_state_t              state_r, state_nxt;
  logic [PTR_W-1:0]         wr_ptr_r;
  logic [PTR_W-1:0]         idx_r;
  logic                     rd_vld_r;
  logic [TICK_W-1:0]        rdata_r;
  logic [CNT_W-1:0]         above_r, below_r;
  logic signed [TUNE_W-1:0] tune_r, tune_nxt;

  logic                     start;
  logic                     mem_we;
  logic [VOTE_W-1:0]        above_ext, below_ext, margin_ext;
  logic                     go_down, go_up;
  action_t                  action;

  assign start = (state_r == BK_IDLE) && !q_empty_i && !r_full_i;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE: begin
        if (start && q_desc_i.kind == KIND_VOTE) begin
          state_nxt = BK_WALK;
        end
      end
      BK_WALK: begin
        if (idx_r == LAST_IDX) begin
          state_nxt = BK_DRAIN;
        end
      end
      BK_DRAIN:  state_nxt = BK_DECIDE;
      BK_DECIDE: state_nxt = BK_IDLE;
      default:   state_nxt = BK_IDLE;
    endcase
  end

  // vote decision on the finished counts
  always_comb begin
    above_ext  = VOTE_W'(above_r);
    below_ext  = VOTE_W'(below_r);
    margin_ext = VOTE_W'(margin_i);
    go_down    = above_ext > (below_ext + margin_ext);
    go_up      = !go_down && (below_ext > (above_ext + margin_ext));
    tune_nxt   = tune_r;
    action     = ACT_NONE;
    if (go_down && tune_r != TUNE_MIN) begin
      tune_nxt = tune_r - TUNE_STEP;
      action   = ACT_DOWN;
    end else if (go_up && tune_r != TUNE_MAX) begin
      tune_nxt = tune_r + TUNE_STEP;
      action   = ACT_UP;
    end
  end

  always_comb begin
    q_pop_o  = start;
    mem_we   = start && (q_desc_i.kind == KIND_STORE);
    r_push_o = 1'b0;
    r_res_o  = '{tune: tune_r, action: ACT_NONE, full: q_desc_i.full};
    unique case (state_r)
      BK_IDLE: begin
        r_push_o = start && (q_desc_i.kind != KIND_VOTE);
      end
      BK_DECIDE: begin
        r_push_o = 1'b1;
        r_res_o  = '{tune: tune_nxt, action: action, full: 1'b1};
      end
      default: begin
        r_push_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= BK_IDLE;
      wr_ptr_r <= '0;
      idx_r    <= '0;
      rd_vld_r <= 1'b0;
      above_r  <= '0;
      below_r  <= '0;
      tune_r   <= '0;
    end else begin
      state_r  <= state_nxt;
      rd_vld_r <= (state_r == BK_WALK);
      if (mem_we) begin
        wr_ptr_r <= (wr_ptr_r == LAST_IDX) ? '0 : wr_ptr_r + 1'b1;
      end
      if (start) begin
        idx_r <= '0;
      end else if (state_r == BK_WALK) begin
        idx_r <= idx_r + 1'b1;
      end
      if (start) begin
        above_r <= '0;
        below_r <= '0;
      end else if (rd_vld_r) begin
        if (rdata_r > target_i) begin
          above_r <= above_r + 1'b1;
        end else if (rdata_r < target_i) begin
          below_r <= below_r + 1'b1;
        end
      end
      if (state_r == BK_DECIDE) begin
        tune_r <= tune_nxt;
      end
    end
  end

  // window is a ring: order does not matter to the vote
  always_ff @(posedge clk) begin
    if (mem_we) begin
      win_mem[wr_ptr_r] <= q_desc_i.ticks;
    end
    if (state_r == BK_WALK) begin
      rdata_r <= win_mem[idx_r];
    end
  end

  a_tune_only_on_decide: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != BK_DECIDE) |=> $stable(tune_r))
    else $error("tune changed outside a decision");

  a_down_steps_one: assert property (@(posedge clk) disable iff (!rst_n)
    (r_push_o && r_res_o.action == ACT_DOWN) |=> (tune_r == $past(tune_r) - TUNE_STEP))
    else $error("down action without a single step");

  a_up_steps_one: assert property (@(posedge clk) disable iff (!rst_n)
    (r_push_o && r_res_o.action == ACT_UP) |=> (tune_r == $past(tune_r) + TUNE_STEP))
    else $error("up action without a single step");

  a_no_pop_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != BK_IDLE) |-> !q_pop_o)
    else $error("descriptor taken during a vote");

endmodule

### rtl/oscillator_trim_vote.sv
// Channel   Handshake            Payload
// input     push / full          in_cmd, in_sample_ticks
// result    pop / empty          out_tune_value, out_adjust_action, out_window_full
// config    APB psel/penable     target_ticks at 0x0, vote_margin at 0x4
//
// A record item, or an evaluate item before the window is full, is handled in the idle
// state of the back end; an evaluate item on a full window passes the walk, drain and
// decide states, the single read port walking the window one entry per cycle.
// Reset clears control state only; window entries need none, since a vote waits
// for a full window. Two-entry queues sit between front, back and result port.
module oscillator_trim_vote
  import otv_pkg::*;
#(
  parameter int WINDOW_SAMPLES = WINDOW_SAMPLES_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     push,
  output logic                     full,
  input  logic                     in_cmd,
  input  logic [TICK_W-1:0]        in_sample_ticks,
  output logic                     empty,
  input  logic                     pop,
  output logic signed [TUNE_W-1:0] out_tune_value,
  output logic [1:0]               out_adjust_action,
  output logic                     out_window_full,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [ADDR_W-1:0]        paddr,
  input  logic [DATA_W-1:0]        pwdata,
  output logic [DATA_W-1:0]        prdata,
  output logic                     pready
);

  logic [TICK_W-1:0]   target_r;
  logic [MARGIN_W-1:0] margin_r;
  logic                cfg_wr;

  desc_t desc_in, desc_out;
  logic  cq_push, cq_full, cq_pop, cq_empty;
  res_t  res_in, res_out;
  logic  rq_push, rq_full;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r <= TARGET_RESET;
      margin_r <= MARGIN_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_TARGET: target_r <= pwdata[TICK_W-1:0];
        REG_MARGIN: margin_r <= pwdata[MARGIN_W-1:0];
        default:    target_r <= target_r;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_TARGET: prdata = DATA_W'(target_r);
      REG_MARGIN: prdata = DATA_W'(margin_r);
      default:    prdata = '0;
    endcase
  end

  otv_front #(
    .WINDOW_SAMPLES(WINDOW_SAMPLES)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .push_i   (push),
    .cmd_i    (in_cmd),
    .ticks_i  (in_sample_ticks),
    .q_full_i (cq_full),
    .q_push_o (cq_push),
    .q_desc_o (desc_in)
  );

  assign full = cq_full;

  otv_fifo #(
    .WIDTH($bits(desc_t)),
    .DEPTH(QUEUE_DEPTH)
  ) u_cmd_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_i  (cq_push),
    .din_i   (desc_in),
    .full_o  (cq_full),
    .pop_i   (cq_pop),
    .dout_o  (desc_out),
    .empty_o (cq_empty)
  );

  otv_back #(
    .WINDOW_SAMPLES(WINDOW_SAMPLES)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty_i (cq_empty),
    .q_desc_i  (desc_out),
    .q_pop_o   (cq_pop),
    .target_i  (target_r),
    .margin_i  (margin_r),
    .r_full_i  (rq_full),
    .r_push_o  (rq_push),
    .r_res_o   (res_in)
  );

  otv_fifo #(
    .WIDTH($bits(res_t)),
    .DEPTH(QUEUE_DEPTH)
  ) u_res_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_i  (rq_push),
    .din_i   (res_in),
    .full_o  (rq_full),
    .pop_i   (pop),
    .dout_o  (res_out),
    .empty_o (empty)
  );

  assign out_tune_value    = res_out.tune;
  assign out_adjust_action = res_out.action;
  assign out_window_full   = res_out.full;

endmodule
